FILE: src/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg - shared types and constants of the lidar scan point segmenter
// sizes, register indexes, sequencer states and the cordic arctangent table
// ----------------------------------------------------------------------------
package lsps_pkg;

  // scan and angle format
  localparam int SCAN_POINTS = 1024;
  localparam int ANGLE_BITS  = 16;
  localparam int IDX_W       = $clog2(SCAN_POINTS);
  localparam int PHASE_SH    = 32 - ANGLE_BITS;

  // field widths
  localparam int RANGE_W  = 16;
  localparam int REG16_W  = 16;
  localparam int COORD_W  = 24;
  localparam int SEG_W    = 10;
  localparam int KEPT_W   = 11;
  localparam int OUT_DATA_W = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // shared arithmetic
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CW     = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 4;
  localparam int DIST_W = 33;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  // register reset values
  localparam logic [REG16_W-1:0] ANGLE_STEP_RST  = 16'd182;
  localparam logic [REG16_W-1:0] SEGMENT_GAP_RST = 16'd179;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_START = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_POSE_X      = 3'd2,
    CFG_POSE_Y      = 3'd3,
    CFG_POSE_YAW    = 3'd4,
    CFG_SEGMENT_GAP = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_SUM,
    ST_ROT,
    ST_ROUND,
    ST_MUL_X,
    ST_ADD_X,
    ST_ADD_Y,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_G,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // atan(2^-k) in units of 2^32 per full turn
  function automatic logic signed [31:0] atan_entry(input logic [STEP_W-1:0] k);
    logic signed [31:0] v;
    unique case (k)
      4'd0:  v = 32'sd536870912;
      4'd1:  v = 32'sd316933406;
      4'd2:  v = 32'sd167458907;
      4'd3:  v = 32'sd85004756;
      4'd4:  v = 32'sd42667331;
      4'd5:  v = 32'sd21354465;
      4'd6:  v = 32'sd10680862;
      4'd7:  v = 32'sd5340245;
      4'd8:  v = 32'sd2670163;
      4'd9:  v = 32'sd1335087;
      4'd10: v = 32'sd667544;
      4'd11: v = 32'sd333772;
      4'd12: v = 32'sd166886;
      4'd13: v = 32'sd83443;
      4'd14: v = 32'sd41722;
      4'd15: v = 32'sd20861;
    endcase
    return v;
  endfunction

endpackage

FILE: src/lidar_scan_point_segmenter_unit.sv
// ----------------------------------------------------------------------------
// lidar_scan_point_segmenter_unit - lidar range samples to segmented world points
// turns each range sample into a world point through an iterative cordic,
// drops invalid samples and splits the kept points into segments by gap
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ----------------------------------------------
//  s_       in   s_tvalid/s_tready  tdata range_sample, tuser sample_invalid,
//                                   tlast last_sample
//  m_       out  m_tvalid/m_tready  tdata world_x..too_few_points,
//                                   tuser point_present, tlast scan_end
//  cfg_     in   cfg_we             cfg_index register, cfg_data value
//
//  sequence: a kept point runs the 16 rotations of the shared cordic shift-add
//  unit and the shared 18x18 multiplier (angle, two offsets, three squares);
//  the first kept point of a scan skips the squares and a dropped sample skips
//  both, so a new request is taken only once the current one is done
//  reset: synchronous rst clears the sequencer, scan state, output valid and
//  loads the register reset values
//  stalls: a held-off result sits in the output register while the next
//  request is taken; the sequencer waits in its last step only if a new
//  result is due and the output register is still full
//
module lidar_scan_point_segmenter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lsps_pkg::RANGE_W-1:0]         s_tdata,   // [15:0] range_sample
  input  logic                                 s_tuser,   // [0] sample_invalid
  input  logic                                 s_tlast,   // last_sample
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [23:0] world_x, [47:24] world_y, [57:48] segment_number,
  // [58] segment_start, [59] too_few_points, [63:60] zero
  output logic [lsps_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser,   // [0] point_present
  output logic                                 m_tlast,   // scan_end
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [lsps_pkg::SEG_W-1:0]  SegMax  = {lsps_pkg::SEG_W{1'b1}};
  localparam logic [lsps_pkg::KEPT_W-1:0] KeptMax = {lsps_pkg::KEPT_W{1'b1}};
  localparam logic [lsps_pkg::IDX_W-1:0]  IdxLast =
    lsps_pkg::IDX_W'(lsps_pkg::SCAN_POINTS - 1);
  localparam logic [lsps_pkg::STEP_W-1:0] StepLast =
    lsps_pkg::STEP_W'(lsps_pkg::CORDIC_STEPS - 1);

  // saturate to signed 24 bits
  function automatic logic signed [lsps_pkg::COORD_W-1:0] sat_coord(
    input logic signed [lsps_pkg::COORD_W+1:0] v);
    logic signed [lsps_pkg::COORD_W-1:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[lsps_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  // saturate cordic result to q1.15
  function automatic logic signed [15:0] sat_q15(input logic signed [lsps_pkg::CW-1:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [lsps_pkg::REG16_W-1:0]        angle_start;
  logic [lsps_pkg::REG16_W-1:0]        angle_step;
  logic signed [lsps_pkg::COORD_W-1:0] pose_x;
  logic signed [lsps_pkg::COORD_W-1:0] pose_y;
  logic [lsps_pkg::REG16_W-1:0]        pose_yaw;
  logic [lsps_pkg::REG16_W-1:0]        segment_gap;

  // sequencer and scan state
  lsps_pkg::state_t state, state_next;
  logic [lsps_pkg::IDX_W-1:0]          idx;
  logic signed [lsps_pkg::COORD_W-1:0] prev_x;
  logic signed [lsps_pkg::COORD_W-1:0] prev_y;
  logic                                have_prev;
  logic [lsps_pkg::SEG_W-1:0]          seg_count;
  logic [lsps_pkg::KEPT_W-1:0]         kept_count;

  // current request
  logic [lsps_pkg::RANGE_W-1:0] range_r;
  logic                         invalid_r;
  logic                         last_r;

  // shared multiplier
  logic signed [lsps_pkg::MUL_W-1:0]  mul_a;
  logic signed [lsps_pkg::MUL_W-1:0]  mul_b;
  logic signed [lsps_pkg::PROD_W-1:0] prod;

  // cordic datapath
  logic signed [lsps_pkg::CW-1:0] x_c;
  logic signed [lsps_pkg::CW-1:0] y_c;
  logic signed [31:0]             z_c;
  logic [1:0]                     quad;
  logic [lsps_pkg::STEP_W-1:0]    k;
  logic signed [16:0]             c_val;
  logic signed [16:0]             s_val;

  // world point and gap test
  logic signed [lsps_pkg::COORD_W-1:0] wx;
  logic signed [lsps_pkg::COORD_W-1:0] wy;
  logic signed [lsps_pkg::COORD_W:0]   dx;
  logic signed [lsps_pkg::COORD_W:0]   dy;
  logic                                far;
  logic [lsps_pkg::DIST_W-1:0]         dist_sum;
  logic                                split;

  // output register
  logic                                out_present;
  logic signed [lsps_pkg::COORD_W-1:0] out_x;
  logic signed [lsps_pkg::COORD_W-1:0] out_y;
  logic [lsps_pkg::SEG_W-1:0]          out_seg;
  logic                                out_start;
  logic                                out_end;
  logic                                out_few;

  // combinational helpers
  logic                          accept;
  logic                          done_fire;
  logic                          need_out;
  logic [lsps_pkg::ANGLE_BITS-1:0] angle;
  logic [31:0]                   phase;
  logic [31:0]                   phase_rnd;
  logic [31:0]                   rem;
  logic signed [lsps_pkg::CW-1:0] xs;
  logic signed [lsps_pkg::CW-1:0] ys;
  logic signed [31:0]            at_k;
  logic signed [15:0]            cq;
  logic signed [15:0]            sq;
  logic signed [16:0]            c_map;
  logic signed [16:0]            s_map;
  logic signed [lsps_pkg::PROD_W-1:0]  off_w;
  logic signed [lsps_pkg::COORD_W+1:0] coord_sum;
  logic signed [lsps_pkg::COORD_W-1:0] coord_sat;
  logic signed [lsps_pkg::COORD_W:0]   dx_now;
  logic signed [lsps_pkg::COORD_W:0]   dy_now;
  logic [lsps_pkg::COORD_W:0]          dx_abs;
  logic [lsps_pkg::COORD_W:0]          dy_abs;
  logic [lsps_pkg::KEPT_W-1:0]         kept_after;
  logic [lsps_pkg::SEG_W-1:0]          seg_after;
  logic                                start_now;
  logic [lsps_pkg::IDX_W-1:0]          idx_next;

  // ---------------------------------------------------------------------------
  // configuration writes, indexes past the list are ignored
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= '0;
      angle_step  <= lsps_pkg::ANGLE_STEP_RST;
      pose_x      <= '0;
      pose_y      <= '0;
      pose_yaw    <= '0;
      segment_gap <= lsps_pkg::SEGMENT_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsps_pkg::CFG_ANGLE_START: angle_start <= cfg_data[lsps_pkg::REG16_W-1:0];
        lsps_pkg::CFG_ANGLE_STEP:  angle_step  <= cfg_data[lsps_pkg::REG16_W-1:0];
        lsps_pkg::CFG_POSE_X:      pose_x      <= cfg_data;
        lsps_pkg::CFG_POSE_Y:      pose_y      <= cfg_data;
        lsps_pkg::CFG_POSE_YAW:    pose_yaw    <= cfg_data[lsps_pkg::REG16_W-1:0];
        lsps_pkg::CFG_SEGMENT_GAP: segment_gap <= cfg_data[lsps_pkg::REG16_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      lsps_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = s_tuser ? lsps_pkg::ST_DONE : lsps_pkg::ST_ANG_MUL;
        end
      end
      lsps_pkg::ST_ANG_MUL: state_next = lsps_pkg::ST_ANG_SUM;
      lsps_pkg::ST_ANG_SUM: state_next = lsps_pkg::ST_ROT;
      lsps_pkg::ST_ROT: begin
        if (k == StepLast) begin
          state_next = lsps_pkg::ST_ROUND;
        end
      end
      lsps_pkg::ST_ROUND:  state_next = lsps_pkg::ST_MUL_X;
      lsps_pkg::ST_MUL_X:  state_next = lsps_pkg::ST_ADD_X;
      lsps_pkg::ST_ADD_X:  state_next = lsps_pkg::ST_ADD_Y;
      lsps_pkg::ST_ADD_Y:  state_next = have_prev ? lsps_pkg::ST_DIFF : lsps_pkg::ST_DONE;
      lsps_pkg::ST_DIFF:   state_next = lsps_pkg::ST_SQ_X;
      lsps_pkg::ST_SQ_X:   state_next = lsps_pkg::ST_SQ_Y;
      lsps_pkg::ST_SQ_Y:   state_next = lsps_pkg::ST_SQ_G;
      lsps_pkg::ST_SQ_G:   state_next = lsps_pkg::ST_DECIDE;
      lsps_pkg::ST_DECIDE: state_next = lsps_pkg::ST_DONE;
      lsps_pkg::ST_DONE: begin
        if (!need_out || !m_tvalid || m_tready) begin
          state_next = lsps_pkg::ST_IDLE;
        end
      end
      default: state_next = lsps_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs: handshake and multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    s_tready  = (state == lsps_pkg::ST_IDLE);
    need_out  = !invalid_r || last_r;
    done_fire = (state == lsps_pkg::ST_DONE) && (!need_out || !m_tvalid || m_tready);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      lsps_pkg::ST_ANG_MUL: begin
        mul_a = $signed({{(lsps_pkg::MUL_W - lsps_pkg::IDX_W){1'b0}}, idx});
        mul_b = $signed({2'b00, angle_step});
      end
      lsps_pkg::ST_MUL_X: begin
        mul_a = $signed({2'b00, range_r});
        mul_b = $signed({c_val[16], c_val});
      end
      lsps_pkg::ST_ADD_X: begin
        mul_a = $signed({2'b00, range_r});
        mul_b = $signed({s_val[16], s_val});
      end
      // squares only matter when both deltas are below the gap, so 18 bits hold them
      lsps_pkg::ST_SQ_X: begin
        mul_a = dx[lsps_pkg::MUL_W-1:0];
        mul_b = dx[lsps_pkg::MUL_W-1:0];
      end
      lsps_pkg::ST_SQ_Y: begin
        mul_a = dy[lsps_pkg::MUL_W-1:0];
        mul_b = dy[lsps_pkg::MUL_W-1:0];
      end
      lsps_pkg::ST_SQ_G: begin
        mul_a = $signed({2'b00, segment_gap});
        mul_b = $signed({2'b00, segment_gap});
      end
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // datapath combinational pieces
  // ---------------------------------------------------------------------------
  always_comb begin
    // beam angle wraps at a full turn
    angle = lsps_pkg::ANGLE_BITS'(prod[lsps_pkg::ANGLE_BITS-1:0]
            + lsps_pkg::ANGLE_BITS'(angle_start) + lsps_pkg::ANGLE_BITS'(pose_yaw));
    phase     = 32'(angle) << lsps_pkg::PHASE_SH;
    // nearest quarter turn and the remainder around it
    phase_rnd = phase + 32'h2000_0000;
    rem       = phase - {phase_rnd[31:30], 30'd0};

    // one cordic rotation
    xs   = x_c >>> k;
    ys   = y_c >>> k;
    at_k = lsps_pkg::atan_entry(k);

    // round to q1.15 and fold back into the quadrant
    cq = sat_q15((x_c + 34'sd16384) >>> 15);
    sq = sat_q15((y_c + 34'sd16384) >>> 15);
    unique case (quad)
      2'd0: begin c_map = {cq[15], cq};   s_map = {sq[15], sq};   end
      2'd1: begin c_map = -{sq[15], sq};  s_map = {cq[15], cq};   end
      2'd2: begin c_map = -{cq[15], cq};  s_map = -{sq[15], sq};  end
      default: begin c_map = {sq[15], sq}; s_map = -{cq[15], cq}; end
    endcase

    // pose plus rounded offset, shared by x and y steps
    off_w     = (prod + 36'sd16384) >>> 15;
    coord_sum = (state == lsps_pkg::ST_ADD_X) ?
                {{2{pose_x[lsps_pkg::COORD_W-1]}}, pose_x} + off_w[lsps_pkg::COORD_W+1:0] :
                {{2{pose_y[lsps_pkg::COORD_W-1]}}, pose_y} + off_w[lsps_pkg::COORD_W+1:0];
    coord_sat = sat_coord(coord_sum);

    // deltas to the previous point; far means the gap is met without squaring
    dx_now = {wx[lsps_pkg::COORD_W-1], wx} - {prev_x[lsps_pkg::COORD_W-1], prev_x};
    dy_now = {wy[lsps_pkg::COORD_W-1], wy} - {prev_y[lsps_pkg::COORD_W-1], prev_y};
    dx_abs = dx_now[lsps_pkg::COORD_W] ? -dx_now : dx_now;
    dy_abs = dy_now[lsps_pkg::COORD_W] ? -dy_now : dy_now;

    // scan state after this request
    kept_after = (invalid_r || kept_count == KeptMax) ? kept_count : kept_count + 1'b1;
    seg_after  = (!invalid_r && have_prev && split && seg_count != SegMax) ?
                 seg_count + 1'b1 : seg_count;
    start_now  = !invalid_r && (!have_prev || split);
    idx_next   = (idx == IdxLast) ? '0 : idx + 1'b1;
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lsps_pkg::ST_IDLE;
      idx        <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      have_prev  <= 1'b0;
      seg_count  <= '0;
      kept_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (done_fire && need_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (done_fire) begin
        if (last_r) begin
          // scan end returns all scan state to reset
          idx        <= '0;
          prev_x     <= '0;
          prev_y     <= '0;
          have_prev  <= 1'b0;
          seg_count  <= '0;
          kept_count <= '0;
        end else begin
          idx <= idx_next;
          if (!invalid_r) begin
            prev_x     <= wx;
            prev_y     <= wy;
            have_prev  <= 1'b1;
            seg_count  <= seg_after;
            kept_count <= kept_after;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (accept) begin
      range_r   <= s_tdata;
      invalid_r <= s_tuser;
      last_r    <= s_tlast;
    end

    unique case (state)
      lsps_pkg::ST_ANG_SUM: begin
        x_c  <= lsps_pkg::CORDIC_X0;
        y_c  <= '0;
        z_c  <= $signed(rem);
        quad <= phase_rnd[31:30];
        k    <= '0;
      end
      lsps_pkg::ST_ROT: begin
        if (z_c[31]) begin
          x_c <= x_c + ys;
          y_c <= y_c - xs;
          z_c <= z_c + at_k;
        end else begin
          x_c <= x_c - ys;
          y_c <= y_c + xs;
          z_c <= z_c - at_k;
        end
        k <= k + 1'b1;
      end
      lsps_pkg::ST_ROUND: begin
        c_val <= c_map;
        s_val <= s_map;
      end
      lsps_pkg::ST_ADD_X: wx <= coord_sat;
      lsps_pkg::ST_ADD_Y: wy <= coord_sat;
      lsps_pkg::ST_DIFF: begin
        dx  <= dx_now;
        dy  <= dy_now;
        far <= (dx_abs >= (lsps_pkg::COORD_W+1)'(segment_gap)) ||
               (dy_abs >= (lsps_pkg::COORD_W+1)'(segment_gap));
      end
      lsps_pkg::ST_SQ_Y: dist_sum <= prod[lsps_pkg::DIST_W-1:0];
      lsps_pkg::ST_SQ_G: dist_sum <= dist_sum + prod[lsps_pkg::DIST_W-1:0];
      lsps_pkg::ST_DECIDE: split <= far || (dist_sum >= prod[lsps_pkg::DIST_W-1:0]);
      default: ;
    endcase

    if (done_fire && need_out) begin
      out_present <= !invalid_r;
      out_x       <= invalid_r ? '0 : wx;
      out_y       <= invalid_r ? '0 : wy;
      out_seg     <= invalid_r ? '0 : seg_after;
      out_start   <= start_now;
      out_end     <= last_r;
      out_few     <= last_r && (kept_after < lsps_pkg::KEPT_W'(2));
    end
  end

  assign m_tdata = {4'd0, out_few, out_start, out_seg, out_y, out_x};
  assign m_tuser = out_present;
  assign m_tlast = out_end;

endmodule
